// File: src/ddo_pkg.sv
// Package with shared constants, types and helper functions for the odometry block.
`default_nettype none
package ddo_pkg;

   localparam int COUNTER_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int WRAP_LIMIT_DEF   = 30000;

   localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;

   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_SPEED  = 2'd1;
   localparam logic [1:0] CMD_RESET  = 2'd2;

   localparam logic [2:0] REG_RIGHT_GAIN  = 3'd0;
   localparam logic [2:0] REG_LEFT_GAIN   = 3'd1;
   localparam logic [2:0] REG_RIGHT_REV   = 3'd2;
   localparam logic [2:0] REG_LEFT_REV    = 3'd3;
   localparam logic [2:0] REG_TURN_GAIN   = 3'd4;
   localparam logic [2:0] REG_LOOKAHEAD   = 3'd5;
   localparam logic [2:0] REG_SPEED_SCALE = 3'd6;
   localparam logic [2:0] REG_WHEEL_RATIO = 3'd7;

   // Arctangent table in binary angle units.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      begin
         unique case (idx)
            5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;  5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;  5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;  5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;  5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;  5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
         endcase
         atan_entry = r;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      begin
         if (v > 64'sd2147483647) sat32 = 32'h7FFFFFFF;
         else if (v < -64'sd2147483648) sat32 = 32'h80000000;
         else sat32 = v[31:0];
      end
   endfunction

   typedef struct packed {
      logic [31:0] right_gain;
      logic [31:0] left_gain;
      logic        right_reverse;
      logic        left_reverse;
      logic [31:0] turn_gain;
      logic [30:0] lookahead;
      logic [31:0] speed_scale;
      logic [31:0] wheel_ratio;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] right_count;
      logic [15:0] left_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] right_travel;
      logic signed [31:0] left_travel;
      logic signed [31:0] centre_travel;
      logic signed [31:0] right_velocity;
      logic signed [31:0] left_velocity;
      logic signed [31:0] turn_rate;
      logic [31:0]        tick_count;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/ddo_req_if.sv
// Valid/ready channel interfaces for request and response transfers.
`default_nettype none
interface ddo_req_if;
   logic             valid;
   logic             ready;
   ddo_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddo_rsp_if;
   logic             valid;
   logic             ready;
   ddo_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/differential_drive_odometry.sv
// Top level: register port, sequencer, two wheel lanes, CORDIC lane and merging stage.
// An update command makes two passes through the iterative CORDIC lane; a speed command
// runs the speed steps, and a pose reset or unused command goes straight to output. The
// next item is taken once the result has moved into the output register, where it waits
// while that item runs; a result not yet taken there holds the output step.
// Synchronous reset clears pose, totals, windows, speeds and counters, and sets register values to their defaults.
`default_nettype none
module differential_drive_odometry #(
   parameter int COUNTER_BITS = ddo_pkg::COUNTER_BITS_DEF,
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
   parameter int WRAP_LIMIT   = ddo_pkg::WRAP_LIMIT_DEF
) (
   input  wire         clock,
   input  wire         reset,
   ddo_req_if.sink     req,
   ddo_rsp_if.source   rsp,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ddo_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LANE  = 4'd1;
   localparam logic [3:0] ST_DIST  = 4'd2;
   localparam logic [3:0] ST_COS1  = 4'd3;
   localparam logic [3:0] ST_MUL1  = 4'd4;
   localparam logic [3:0] ST_HEAD  = 4'd5;
   localparam logic [3:0] ST_COS2  = 4'd6;
   localparam logic [3:0] ST_MUL2  = 4'd7;
   localparam logic [3:0] ST_SP1   = 4'd8;
   localparam logic [3:0] ST_SP2   = 4'd9;
   localparam logic [3:0] ST_SP3   = 4'd10;
   localparam logic [3:0] ST_SP4   = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;
   localparam logic [3:0] ST_HEADM = 4'd13;
   localparam logic [3:0] ST_MUL1B = 4'd14;
   localparam logic [3:0] ST_MUL2B = 4'd15;

   cfg_type cfg_ff;
   logic [2:0] reg_idx;
   logic csr_wr;
   assign reg_idx = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (reg_idx)
         REG_RIGHT_GAIN:  csr_prdata = cfg_ff.right_gain;
         REG_LEFT_GAIN:   csr_prdata = cfg_ff.left_gain;
         REG_RIGHT_REV:   csr_prdata = {31'd0, cfg_ff.right_reverse};
         REG_LEFT_REV:    csr_prdata = {31'd0, cfg_ff.left_reverse};
         REG_TURN_GAIN:   csr_prdata = cfg_ff.turn_gain;
         REG_LOOKAHEAD:   csr_prdata = {1'b0, cfg_ff.lookahead};
         REG_SPEED_SCALE: csr_prdata = cfg_ff.speed_scale;
         REG_WHEEL_RATIO: csr_prdata = cfg_ff.wheel_ratio;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{right_gain: 32'd65536, left_gain: 32'd65536, right_reverse: 1'b0,
                     left_reverse: 1'b0, turn_gain: 32'd65536, lookahead: 31'd6553600,
                     speed_scale: 32'd65536000, wheel_ratio: 32'd32768};
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_RIGHT_GAIN:  cfg_ff.right_gain <= csr_pwdata;
            REG_LEFT_GAIN:   cfg_ff.left_gain <= csr_pwdata;
            REG_RIGHT_REV:   cfg_ff.right_reverse <= csr_pwdata[0];
            REG_LEFT_REV:    cfg_ff.left_reverse <= csr_pwdata[0];
            REG_TURN_GAIN:   cfg_ff.turn_gain <= csr_pwdata;
            REG_LOOKAHEAD:   cfg_ff.lookahead <= csr_pwdata[30:0];
            REG_SPEED_SCALE: cfg_ff.speed_scale <= csr_pwdata;
            REG_WHEEL_RATIO: cfg_ff.wheel_ratio <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Architectural state.
   logic [3:0] state_ff, state_in;
   logic [COUNTER_BITS-1:0] prev_r_ff, prev_l_ff;
   logic signed [31:0] x_ff, y_ff, tx_ff, ty_ff;
   logic [31:0] head_ff, cnt_ff;
   logic signed [31:0] tot_ff [3];
   logic signed [31:0] win_ff [3];
   logic signed [31:0] spd_ff [3];
   logic [15:0] rc_ff, lc_ff;
   logic signed [31:0] dr_ff, dl_ff, dc_ff;
   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [63:0] hd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic out_go;

   logic signed [31:0] dr_w, dl_w;
   logic lane_load;
   logic cor_start, cor_done;
   logic [31:0] cor_angle;
   logic signed [33:0] cos_w, sin_w;

   assign lane_load = (state_ff == ST_LANE);
   assign out_go = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);

   ddo_wheel_lane #(.COUNTER_BITS(COUNTER_BITS), .WRAP_LIMIT(WRAP_LIMIT)) u_right (
      .clock(clock), .load(lane_load), .count(COUNTER_BITS'(rc_ff)),
      .prev(prev_r_ff), .reverse(cfg_ff.right_reverse), .gain(cfg_ff.right_gain),
      .distance(dr_w));
   ddo_wheel_lane #(.COUNTER_BITS(COUNTER_BITS), .WRAP_LIMIT(WRAP_LIMIT)) u_left (
      .clock(clock), .load(lane_load), .count(COUNTER_BITS'(lc_ff)),
      .prev(prev_l_ff), .reverse(cfg_ff.left_reverse), .gain(cfg_ff.left_gain),
      .distance(dl_w));

   assign cor_start = (state_ff == ST_DIST) || (state_ff == ST_HEADM);
   // The second pass starts on the heading as it stands after this update.
   assign cor_angle = (state_ff == ST_HEADM) ? head_ff + hd_ff[31:0] : head_ff;

   ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(cor_angle),
      .done(cor_done), .cos_out(cos_w), .sin_out(sin_w));

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // Truncate-toward-zero magnitude multiply split into 16-bit gain halves.
   function automatic logic signed [63:0] smul(input logic signed [34:0] a,
                                               input logic [31:0] g,
                                               input logic [1:0] sel);
      logic [34:0] m;
      logic [63:0] hi, lo, r;
      begin
         m = a[34] ? 35'(-a) : 35'(a);
         hi = 64'(m) * 64'(g[31:16]);
         lo = 64'(m) * 64'(g[15:0]);
         if (sel == 2'd0) r = hi + (lo >> 16);
         else r = (hi + (lo >> 16)) >> 16;
         smul = a[34] ? -$signed(r) : $signed(r);
      end
   endfunction

   logic signed [31:0] rs_w, ls_w, tr_w;
   logic signed [63:0] mean_w, sum_w;
   logic signed [63:0] dt_w;
   assign rs_w = sat32(pa_ff);
   assign ls_w = sat32(pb_ff);
   assign tr_w = sat32(pc_ff);
   assign sum_w = 64'(rs_w) + 64'(ls_w);
   assign mean_w = sum_w / 2;
   assign dt_w = pd_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req.valid && req.ready) begin
            unique case (req.data.command)
               CMD_UPDATE: state_in = ST_LANE;
               CMD_SPEED:  state_in = ST_SP1;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_LANE:  state_in = ST_DIST;
         ST_DIST:  state_in = ST_COS1;
         ST_COS1:  if (cor_done) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL1B;
         ST_MUL1B: state_in = ST_HEAD;
         ST_HEAD:  state_in = ST_HEADM;
         ST_HEADM: state_in = ST_COS2;
         ST_COS2:  if (cor_done) state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL2B;
         ST_MUL2B: state_in = ST_OUT;
         ST_SP1:   state_in = ST_SP2;
         ST_SP2:   state_in = ST_SP3;
         ST_SP3:   state_in = ST_SP4;
         ST_SP4:   state_in = ST_OUT;
         ST_OUT:   if (out_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_r_ff <= '0; prev_l_ff <= '0;
         x_ff <= '0; y_ff <= '0; tx_ff <= '0; ty_ff <= '0;
         head_ff <= '0; cnt_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            tot_ff[i] <= '0; win_ff[i] <= '0; spd_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (out_go) rsp_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req.valid && req.ready) begin
               rc_ff <= req.data.right_count;
               lc_ff <= req.data.left_count;
               if (req.data.command == CMD_RESET) begin
                  x_ff <= '0; y_ff <= '0; head_ff <= '0;
               end
            end
            ST_DIST: begin
               dr_ff <= dr_w;
               dl_ff <= dl_w;
               dc_ff <= 32'((64'(dr_w) + 64'(dl_w)) / 2);
               prev_r_ff <= COUNTER_BITS'(rc_ff);
               prev_l_ff <= COUNTER_BITS'(lc_ff);
               tot_ff[0] <= sat32(64'(tot_ff[0]) + 64'(dr_w));
               tot_ff[1] <= sat32(64'(tot_ff[1]) + 64'(dl_w));
               win_ff[0] <= sat32(64'(win_ff[0]) + 64'(dr_w));
               win_ff[1] <= sat32(64'(win_ff[1]) + 64'(dl_w));
            end
            ST_MUL1: begin
               tot_ff[2] <= sat32(64'(tot_ff[2]) + 64'(dc_ff));
               pa_ff <= 64'(dc_ff) * 64'(cos_w);
               pb_ff <= 64'(dc_ff) * 64'(sin_w);
            end
            ST_MUL1B: begin
               x_ff <= sat32(64'(x_ff) + (pa_ff >>> 30));
               y_ff <= sat32(64'(y_ff) + (pb_ff >>> 30));
            end
            ST_HEAD: hd_ff <= smul(35'(64'(dr_ff) - 64'(dl_ff)), cfg_ff.turn_gain, 2'd1);
            ST_HEADM: begin
               head_ff <= head_ff + hd_ff[31:0];
               win_ff[2] <= sat32(64'(win_ff[2]) + hd_ff);
               cnt_ff <= cnt_ff + 32'd1;
            end
            ST_MUL2: begin
               pa_ff <= 64'({1'b0, cfg_ff.lookahead}) * 64'(cos_w);
               pb_ff <= 64'({1'b0, cfg_ff.lookahead}) * 64'(sin_w);
            end
            ST_MUL2B: begin
               tx_ff <= sat32(64'(x_ff) + (pa_ff >>> 30));
               ty_ff <= sat32(64'(y_ff) + (pb_ff >>> 30));
            end
            ST_SP1: begin
               pa_ff <= smul(35'(win_ff[0]), cfg_ff.speed_scale, 2'd0);
               pb_ff <= smul(35'(win_ff[1]), cfg_ff.speed_scale, 2'd0);
               pc_ff <= smul(35'(win_ff[2]), cfg_ff.speed_scale, 2'd0);
            end
            ST_SP2: pd_ff <= smul(35'(64'(rs_w) - 64'(ls_w)), cfg_ff.wheel_ratio, 2'd0);
            ST_SP3: begin
               spd_ff[0] <= sat32(mean_w + dt_w);
               spd_ff[1] <= sat32(mean_w - dt_w);
               spd_ff[2] <= tr_w;
               for (int i = 0; i < 3; i++) win_ff[i] <= '0;
            end
            default: ;
         endcase
      end
      if (out_go) begin
         rsp_ff <= '{pos_x: x_ff, pos_y: y_ff, heading: head_ff, target_x: tx_ff,
                     target_y: ty_ff, right_travel: tot_ff[0], left_travel: tot_ff[1],
                     centre_travel: tot_ff[2], right_velocity: spd_ff[0],
                     left_velocity: spd_ff[1], turn_rate: spd_ff[2], tick_count: cnt_ff};
      end
   end

   // A waiting result holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result changed before transfer");
   // A result is raised only from the output step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");
   // The update count only moves during the heading step.
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> $past(state_ff) == ST_HEADM)
      else $error("tick count moved unexpectedly");
endmodule
`default_nettype wire

// File: src/ddo_cordic.sv
// Iterative CORDIC lane computing cosine and sine of a binary angle, one step per cycle.
`default_nettype none
module ddo_cordic #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire [31:0]         angle,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   import ddo_pkg::*;

   localparam int STEP_BITS = $clog2(CORDIC_STEPS + 1);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic busy_ff, busy_in, flip_ff, flip_in, done_ff, done_in;
   logic [31:0] rot;
   logic signed [33:0] xs, ys, at;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; step_in = step_ff;
      busy_in = busy_ff; flip_in = flip_ff; done_in = 1'b0;
      rot = angle;
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = $signed({2'b00, atan_entry(5'(step_ff))});
      if (start) begin
         flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
         rot = flip_in ? angle + 32'h80000000 : angle;
         x_in = $signed({2'b00, CORDIC_K_Q30});
         y_in = '0;
         z_in = {{2{rot[31]}}, rot};
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      step_ff <= step_in; flip_ff <= flip_in;
   end

   assign done = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

// File: src/ddo_wheel_lane.sv
// Wheel lane: wrap-corrected count change scaled by the distance per count.
`default_nettype none
module ddo_wheel_lane #(
   parameter int COUNTER_BITS = ddo_pkg::COUNTER_BITS_DEF,
   parameter int WRAP_LIMIT   = ddo_pkg::WRAP_LIMIT_DEF
) (
   input  wire                    clock,
   input  wire                    load,
   input  wire [COUNTER_BITS-1:0] count,
   input  wire [COUNTER_BITS-1:0] prev,
   input  wire                    reverse,
   input  wire [31:0]             gain,
   output logic signed [31:0]     distance
);
   import ddo_pkg::*;

   localparam int DW = COUNTER_BITS + 18;
   localparam logic signed [DW-1:0] LIMIT = DW'(WRAP_LIMIT);
   localparam logic signed [DW-1:0] SPAN = DW'(1) << COUNTER_BITS;

   logic signed [DW-1:0] d, dw;
   logic [COUNTER_BITS:0] mag;
   logic neg_ff, neg_in;
   logic [COUNTER_BITS+16:0] hi_ff, lo_ff, hi_in, lo_in;
   logic [63:0] r;

   always_comb begin
      d = $signed(DW'(count)) - $signed(DW'(prev));
      if (reverse) d = -d;
      // The two wrap steps run in turn, so a change a little above the limit
      // is folded down and then back up again.
      dw = d;
      if (dw > LIMIT) dw = dw - SPAN;
      if (dw < -LIMIT) dw = dw + SPAN;
      neg_in = dw[DW-1];
      mag = (COUNTER_BITS+1)'(neg_in ? -dw : dw);
      hi_in = (COUNTER_BITS+17)'(mag) * (COUNTER_BITS+17)'(gain[31:16]);
      lo_in = (COUNTER_BITS+17)'(mag) * (COUNTER_BITS+17)'(gain[15:0]);
      r = (64'(hi_ff) << 8) + (64'(lo_ff) >> 8);
      distance = neg_ff ? sat32(-$signed(r)) : sat32($signed(r));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff <= neg_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 1ps
`default_nettype none

import ddo_pkg::*;

class odometry_scoreboard;
   cfg_type cfg;
   bit [15:0] last_right, last_left;
   bit signed [31:0] x_pos, y_pos, tgt_x, tgt_y;
   bit [31:0] bearing, ticks;
   bit signed [31:0] travel [3];
   bit signed [31:0] window [3];
   bit signed [31:0] speeds [3];
   bit [31:0] arctan [24];
   rsp_type pending [$];
   int n_fail, n_checked, n_update, n_speed, n_pose_clear;

   function new();
      arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                 32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
      cfg = '{right_gain: 32'd65536, left_gain: 32'd65536, right_reverse: 1'b0,
              left_reverse: 1'b0, turn_gain: 32'd65536, lookahead: 31'd6553600,
              speed_scale: 32'd65536000, wheel_ratio: 32'd32768};
      last_right = 0; last_left = 0;
      x_pos = 0; y_pos = 0; tgt_x = 0; tgt_y = 0; bearing = 0; ticks = 0;
      foreach (travel[i]) begin
         travel[i] = 0; window[i] = 0; speeds[i] = 0;
      end
   endfunction

   function void write_reg(logic [2:0] idx, bit [31:0] v);
      case (idx)
         REG_RIGHT_GAIN:  cfg.right_gain = v;
         REG_LEFT_GAIN:   cfg.left_gain = v;
         REG_RIGHT_REV:   cfg.right_reverse = v[0];
         REG_LEFT_REV:    cfg.left_reverse = v[0];
         REG_TURN_GAIN:   cfg.turn_gain = v;
         REG_LOOKAHEAD:   cfg.lookahead = v[30:0];
         REG_SPEED_SCALE: cfg.speed_scale = v;
         default:         cfg.wheel_ratio = v;
      endcase
   endfunction

   function bit signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Product with a fractional gain, truncated toward zero.
   function longint scale(longint a, bit [31:0] g, int sh);
      bit neg;
      longint unsigned m, hi, lo, r;
      neg = a < 0;
      m = neg ? -a : a;
      hi = m * g[31:16];
      lo = m * g[15:0];
      if (sh == 8) r = (hi << 8) + (lo >> 8);
      else if (sh == 16) r = hi + (lo >> 16);
      else r = (hi + (lo >> 16)) >> 16;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // Rotation-mode CORDIC giving cosine and sine in Q2.30.
   function void rotate(bit [31:0] ang, output longint c, output longint s);
      bit flip;
      longint x, y, z, nx;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h80000000;
      z = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(arctan[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(arctan[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function longint count_change(bit [15:0] cur, bit [15:0] prev, bit rev);
      longint d;
      d = longint'(cur) - longint'(prev);
      if (rev) d = -d;
      if (d > 30000) d -= 65536;
      if (d < -30000) d += 65536;
      return d;
   endfunction

   function void note(req_type t);
      longint c, s, hd, mean, diff;
      bit signed [31:0] dr, dl, dc, rs, ls;
      rsp_type r;
      if (t.command == CMD_UPDATE) begin
         n_update++;
         dr = clamp(scale(count_change(t.right_count, last_right, cfg.right_reverse),
                          cfg.right_gain, 8));
         dl = clamp(scale(count_change(t.left_count, last_left, cfg.left_reverse),
                          cfg.left_gain, 8));
         last_right = t.right_count;
         last_left = t.left_count;
         dc = (longint'(dr) + longint'(dl)) / 2;
         travel[0] = clamp(longint'(travel[0]) + dr);
         travel[1] = clamp(longint'(travel[1]) + dl);
         travel[2] = clamp(longint'(travel[2]) + dc);
         window[0] = clamp(longint'(window[0]) + dr);
         window[1] = clamp(longint'(window[1]) + dl);
         // Position moves along the heading held before this update.
         rotate(bearing, c, s);
         x_pos = clamp(longint'(x_pos) + ((longint'(dc) * c) >>> 30));
         y_pos = clamp(longint'(y_pos) + ((longint'(dc) * s) >>> 30));
         hd = scale(longint'(dr) - longint'(dl), cfg.turn_gain, 32);
         bearing = bearing + hd[31:0];
         window[2] = clamp(longint'(window[2]) + hd);
         ticks++;
         rotate(bearing, c, s);
         tgt_x = clamp(longint'(x_pos) + ((longint'(cfg.lookahead) * c) >>> 30));
         tgt_y = clamp(longint'(y_pos) + ((longint'(cfg.lookahead) * s) >>> 30));
      end else if (t.command == CMD_SPEED) begin
         n_speed++;
         rs = clamp(scale(window[0], cfg.speed_scale, 16));
         ls = clamp(scale(window[1], cfg.speed_scale, 16));
         speeds[2] = clamp(scale(window[2], cfg.speed_scale, 16));
         mean = (longint'(rs) + longint'(ls)) / 2;
         diff = scale(longint'(rs) - longint'(ls), cfg.wheel_ratio, 16);
         speeds[0] = clamp(mean + diff);
         speeds[1] = clamp(mean - diff);
         foreach (window[i]) window[i] = 0;
      end else if (t.command == CMD_RESET) begin
         n_pose_clear++;
         x_pos = 0; y_pos = 0; bearing = 0;
      end
      r.pos_x = x_pos; r.pos_y = y_pos; r.heading = bearing;
      r.target_x = tgt_x; r.target_y = tgt_y;
      r.right_travel = travel[0]; r.left_travel = travel[1]; r.centre_travel = travel[2];
      r.right_velocity = speeds[0]; r.left_velocity = speeds[1]; r.turn_rate = speeds[2];
      r.tick_count = ticks;
      pending.push_back(r);
   endfunction

   function void compare(string name, bit [31:0] e, bit [31:0] a, ref bit bad);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         bad = 1;
      end
   endfunction

   function void check(rsp_type a);
      rsp_type e;
      bit bad;
      if (pending.size() == 0) begin
         $error("unexpected result transfer");
         n_fail++;
         return;
      end
      e = pending.pop_front();
      bad = 0;
      compare("pos_x", e.pos_x, a.pos_x, bad);
      compare("pos_y", e.pos_y, a.pos_y, bad);
      compare("heading", e.heading, a.heading, bad);
      compare("target_x", e.target_x, a.target_x, bad);
      compare("target_y", e.target_y, a.target_y, bad);
      compare("right_travel", e.right_travel, a.right_travel, bad);
      compare("left_travel", e.left_travel, a.left_travel, bad);
      compare("centre_travel", e.centre_travel, a.centre_travel, bad);
      compare("right_velocity", e.right_velocity, a.right_velocity, bad);
      compare("left_velocity", e.left_velocity, a.left_velocity, bad);
      compare("turn_rate", e.turn_rate, a.turn_rate, bad);
      compare("tick_count", e.tick_count, a.tick_count, bad);
      n_checked++;
      if (bad) n_fail++;
   endfunction
endclass

module tb_differential_drive_odometry;
   localparam int IDLE_LIMIT = 20000;

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   ddo_req_if req ();
   ddo_rsp_if rsp ();

   odometry_scoreboard board;
   bit steady;
   bit moved;
   int idle_cycles, stall_left;
   bit [15:0] right_at, left_at;

   differential_drive_odometry dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int pick_gap();
      if (steady) return 0;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(10, 60);
   endfunction

   // Result side stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (req.valid && req.ready) begin
            board.note(req.data);
            moved = 1'b1;
         end
         if (rsp.valid && rsp.ready) begin
            board.check(rsp.data);
            moved = 1'b1;
         end
         if (csr_psel && csr_penable) moved = 1'b1;
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("differential_drive_odometry verification failed");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, bit [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      board.write_reg(idx, v);
   endtask

   task automatic send(logic [1:0] cmd, bit [15:0] rc, bit [15:0] lc);
      int n;
      req_type t;
      n = pick_gap();
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      t.command = cmd;
      t.right_count = rc;
      t.left_count = lc;
      req.valid <= 1'b1;
      req.data <= t;
      if (cmd == CMD_UPDATE) begin
         right_at = rc;
         left_at = lc;
      end
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Lets the block run dry so that registers can change safely.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic move(int span);
      int dr, dl;
      dr = $urandom_range(0, 2 * span) - span;
      dl = $urandom_range(0, 2 * span) - span;
      send(CMD_UPDATE, right_at + 16'(dr), left_at + 16'(dl));
   endtask

   task automatic random_items(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         k = $urandom_range(0, 99);
         if (k < 60) move(300);
         else if (k < 70) move(32767);
         else if (k < 75) send(CMD_UPDATE, 16'($urandom), 16'($urandom));
         else if (k < 88) send(CMD_SPEED, 16'($urandom), 16'($urandom));
         else if (k < 95) send(CMD_RESET, 16'($urandom), 16'($urandom));
         else send(2'd3, 16'($urandom), 16'($urandom));
         // The sender waits once for all outstanding results mid-stream.
         if (i == count / 2) drain();
      end
      steady = 0;
   endtask

   task automatic load_all(bit [31:0] rg, bit [31:0] lg, bit rr, bit lr, bit [31:0] tg,
                           bit [31:0] la, bit [31:0] ss, bit [31:0] wr);
      write_csr(REG_RIGHT_GAIN, rg);
      write_csr(REG_LEFT_GAIN, lg);
      write_csr(REG_RIGHT_REV, {31'd0, rr});
      write_csr(REG_LEFT_REV, {31'd0, lr});
      write_csr(REG_TURN_GAIN, tg);
      write_csr(REG_LOOKAHEAD, la);
      write_csr(REG_SPEED_SCALE, ss);
      write_csr(REG_WHEEL_RATIO, wr);
   endtask

   initial begin
      board = new();
      steady = 0;
      right_at = 0;
      left_at = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: wrap limits, counter extremes, every command.
      send(CMD_UPDATE, 16'd100, 16'd50);
      send(CMD_UPDATE, 16'd30100, 16'd30050);
      send(CMD_UPDATE, 16'd60101, 16'd51);
      send(CMD_UPDATE, 16'd65535, 16'd65535);
      send(CMD_UPDATE, 16'd0, 16'd0);
      send(CMD_UPDATE, 16'd65535, 16'd1);
      send(CMD_UPDATE, 16'd35535, 16'd31001);
      send(CMD_SPEED, 16'hFFFF, 16'hFFFF);
      send(CMD_UPDATE, 16'd35000, 16'd35500);
      send(2'd3, 16'hFFFF, 16'h0000);
      send(CMD_RESET, 16'h0000, 16'hFFFF);
      send(CMD_SPEED, 16'h0000, 16'h0000);
      send(CMD_UPDATE, 16'h5555, 16'hAAAA);
      send(CMD_UPDATE, 16'hAAAA, 16'h5555);
      random_items(150);
      drain();

      load_all($urandom, $urandom, 1'b1, 1'b0, $urandom, $urandom_range(0, 32'h7FFFFFFF),
               $urandom, $urandom);
      send(CMD_RESET, 16'd0, 16'd0);
      random_items(180);
      drain();

      // Largest gains drive every saturation path.
      load_all(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF, 32'h7FFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF);
      send(CMD_UPDATE, right_at + 16'd30000, left_at - 16'd30000);
      send(CMD_UPDATE, right_at - 16'd30000, left_at + 16'd30000);
      send(CMD_SPEED, 16'd0, 16'd0);
      random_items(150);
      drain();

      load_all(32'd0, 32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
      random_items(40);
      drain();

      load_all(32'd16777216, 32'd16000000, 1'b0, 1'b0, 32'd683565, 32'd6553600,
               32'd65536000, 32'd32768);
      send(CMD_RESET, 16'd0, 16'd0);
      random_items(200);

      req.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("checked %0d results: %0d updates, %0d speed samples, %0d pose clears",
               board.n_checked, board.n_update, board.n_speed, board.n_pose_clear);
      $display("five register settings including all-maximum and all-zero");
      if (board.n_fail == 0 && board.pending.size() == 0) begin
         $display("differential_drive_odometry verification clean");
      end else begin
         if (board.pending.size() != 0)
            $error("%0d expected results never arrived", board.pending.size());
         $display("differential_drive_odometry verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire

// File: sim.f
src/ddo_pkg.sv
src/ddo_req_if.sv
src/ddo_cordic.sv
src/ddo_wheel_lane.sv
src/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
